// ----- rtl/core/hts_pkg.sv -----
`default_nettype none

package hts_pkg;

  // Cell and tetrahedron geometry.
  localparam int unsigned NumCorners = 8;
  localparam int unsigned MaxTets    = 6;
  localparam int unsigned TetCorners = 4;
  localparam int unsigned NumTables  = 4;

  // Width of ids and element numbers on the ports.
  localparam int unsigned OutIdW = 31;

  typedef logic [OutIdW-1:0] vert_t;
  typedef logic [2:0]        corner_t;
  typedef logic [2:0]        tet_cnt_t;
  typedef logic [1:0]        ndiag_t;
  typedef logic [2:0]        diag_code_t;

  // Rotation applied after the minimum corner has been moved to the front.
  typedef enum logic [1:0] {
    ROT_NONE,
    ROT_120,
    ROT_240
  } rot_e;

  // Number of tetrahedra when no face diagonal touches the first corner,
  // and when at least one does.
  localparam tet_cnt_t TetsNoDiag   = 3'd5;
  localparam tet_cnt_t TetsWithDiag = 3'd6;

  // Bit positions of the three face tests in the diagonal code.
  localparam int unsigned CodeBitFaceA = 2;
  localparam int unsigned CodeBitFaceB = 1;
  localparam int unsigned CodeBitFaceC = 0;

  // Diagonal codes that select each rotation.
  localparam diag_code_t CodeRot120Lo = 3'b001;
  localparam diag_code_t CodeRot120Hi = 3'b110;
  localparam diag_code_t CodeRot240Lo = 3'b010;
  localparam diag_code_t CodeRot240Hi = 3'b101;

  // Corner order that brings each corner to position zero.
  localparam corner_t PermMin [NumCorners][NumCorners] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd1, 3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd6},
    '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
    '{3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6},
    '{3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6},
    '{3'd5, 3'd1, 3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7},
    '{3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4},
    '{3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd5}
  };

  // Tetrahedra of the split, one table per number of touching diagonals.
  localparam corner_t TetTbl [NumTables][MaxTets][TetCorners] = '{
    '{'{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd2, 3'd7, 3'd5}, '{3'd0, 3'd2, 3'd3, 3'd7},
      '{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd2, 3'd7, 3'd5, 3'd6}, '{3'd0, 3'd0, 3'd0, 3'd0}},
    '{'{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd0, 3'd1, 3'd7, 3'd5}, '{3'd1, 3'd6, 3'd7, 3'd5},
      '{3'd0, 3'd7, 3'd2, 3'd3}, '{3'd0, 3'd7, 3'd1, 3'd2}, '{3'd1, 3'd7, 3'd6, 3'd2}},
    '{'{3'd0, 3'd4, 3'd5, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
      '{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd3, 3'd6, 3'd2}, '{3'd0, 3'd6, 3'd5, 3'd2}},
    '{'{3'd0, 3'd2, 3'd3, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
      '{3'd0, 3'd5, 3'd6, 3'd4}, '{3'd1, 3'd5, 3'd6, 3'd0}, '{3'd1, 3'd6, 3'd2, 3'd0}}
  };

  // Source corner of a rotated position.
  function automatic corner_t rot_corner(rot_e rot, corner_t pos);
    corner_t res;
    res = pos;
    case (rot)
      ROT_120: begin
        case (pos)
          3'd1:    res = 3'd4;
          3'd2:    res = 3'd5;
          3'd3:    res = 3'd1;
          3'd4:    res = 3'd3;
          3'd5:    res = 3'd7;
          3'd7:    res = 3'd2;
          default: res = pos;
        endcase
      end
      ROT_240: begin
        case (pos)
          3'd1:    res = 3'd3;
          3'd2:    res = 3'd7;
          3'd3:    res = 3'd4;
          3'd4:    res = 3'd1;
          3'd5:    res = 3'd2;
          3'd7:    res = 3'd5;
          default: res = pos;
        endcase
      end
      default: res = pos;
    endcase
    return res;
  endfunction

  // Rotation chosen by the diagonal code.
  function automatic rot_e rot_from_code(diag_code_t code);
    rot_e res;
    if (code inside {CodeRot120Lo, CodeRot120Hi}) begin
      res = ROT_120;
    end else if (code inside {CodeRot240Lo, CodeRot240Hi}) begin
      res = ROT_240;
    end else begin
      res = ROT_NONE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hex_to_tet_split.sv -----
// Path: an accepted cell passes the 4 classifier stages, the queue, the emitter's cell register
// and its output register. Throughput: one tetrahedron per cycle while results are popped, set by the
// single result port of the emitter, and each cell gives 5 or 6; the 4-stage classifier and 2-entry queue take a
// new cell every cycle until they fill.
// Reset: all stages, the queue and the output register empty; the tetrahedron count is
// zero and the first element number is 1.
`default_nettype none

module hex_to_tet_split #(
  parameter int unsigned VERTEX_ID_BITS = 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  hts_pkg::vert_t           cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  hts_pkg::vert_t           vertex_id_1_i,
  input  hts_pkg::vert_t           vertex_id_2_i,
  input  hts_pkg::vert_t           vertex_id_3_i,
  input  hts_pkg::vert_t           vertex_id_4_i,
  input  hts_pkg::vert_t           vertex_id_5_i,
  input  hts_pkg::vert_t           vertex_id_6_i,
  input  hts_pkg::vert_t           vertex_id_7_i,
  input  hts_pkg::vert_t           vertex_id_8_i,
  output logic                     empty,
  input  logic                     pop,
  output hts_pkg::vert_t           tet_number_o,
  output hts_pkg::vert_t           vert_a_o,
  output hts_pkg::vert_t           vert_b_o,
  output hts_pkg::vert_t           vert_c_o,
  output hts_pkg::vert_t           vert_d_o,
  output hts_pkg::tet_cnt_t        tets_in_cell_o,
  output logic                     last_o
);

  // Ids are compared on their low bits only, never wider than the ports.
  localparam int unsigned IdW =
    (VERTEX_ID_BITS < hts_pkg::OutIdW) ? VERTEX_ID_BITS : hts_pkg::OutIdW;
  localparam int unsigned CornersW = hts_pkg::NumCorners * IdW;
  localparam int unsigned QueueW   = CornersW + $bits(hts_pkg::diag_code_t);

  logic [hts_pkg::NumCorners-1:0][IdW-1:0] in_ids, front_corners, cell_corners;
  hts_pkg::diag_code_t                     front_code, cell_code;
  logic                                    in_ready, front_valid, q_full, q_empty;
  logic                                    cell_pop, res_valid;
  logic [QueueW-1:0]                       q_wdata, q_rdata;

  // Masked corner ids.
  assign in_ids[0] = vertex_id_1_i[IdW-1:0];
  assign in_ids[1] = vertex_id_2_i[IdW-1:0];
  assign in_ids[2] = vertex_id_3_i[IdW-1:0];
  assign in_ids[3] = vertex_id_4_i[IdW-1:0];
  assign in_ids[4] = vertex_id_5_i[IdW-1:0];
  assign in_ids[5] = vertex_id_6_i[IdW-1:0];
  assign in_ids[6] = vertex_id_7_i[IdW-1:0];
  assign in_ids[7] = vertex_id_8_i[IdW-1:0];

  assign full = !in_ready;

  // Classifier: minimum corner, permutation and face tests.
  hts_front #(
    .ID_W(IdW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_ready_o (in_ready),
    .ids_i      (in_ids),
    .out_valid_o(front_valid),
    .out_ready_i(!q_full),
    .corners_o  (front_corners),
    .code_o     (front_code)
  );

  // Queue of classified cells.
  assign q_wdata      = {front_code, front_corners};
  assign cell_corners = q_rdata[CornersW-1:0];
  assign cell_code    = q_rdata[CornersW +: $bits(hts_pkg::diag_code_t)];

  hts_fifo #(
    .DATA_W(QueueW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .full_o (q_full),
    .wdata_i(q_wdata),
    .pop_i  (cell_pop),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  // Emitter: one tetrahedron per cycle while the result register is free or popped.
  hts_back #(
    .ID_W(IdW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cell_valid_i  (!q_empty),
    .cell_pop_o    (cell_pop),
    .cell_corners_i(cell_corners),
    .cell_code_i   (cell_code),
    .res_pop_i     (pop),
    .res_valid_o   (res_valid),
    .tet_number_o  (tet_number_o),
    .vert_a_o      (vert_a_o),
    .vert_b_o      (vert_b_o),
    .vert_c_o      (vert_c_o),
    .vert_d_o      (vert_d_o),
    .tets_in_cell_o(tets_in_cell_o),
    .last_o        (last_o)
  );

  assign empty = !res_valid;

  // A shown result always carries a legal tetrahedron count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (tets_in_cell_o == hts_pkg::TetsNoDiag ||
                tets_in_cell_o == hts_pkg::TetsWithDiag))
    else $error("tets_in_cell out of range");

  // Back-to-back results carry consecutive element numbers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) ##1 !empty |->
      tet_number_o == hts_pkg::vert_t'($past(tet_number_o) + hts_pkg::vert_t'(1)))
    else $error("element numbers not consecutive");

  // A cell keeps its count until its last tetrahedron has gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) ##1 !empty |-> tets_in_cell_o == $past(tets_in_cell_o))
    else $error("cell split before its last tetrahedron");

  // The emitter only takes a cell from a non-empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_pop |-> !q_empty)
    else $error("cell taken from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/hts_front.sv -----
`default_nettype none

module hts_front #(
  parameter int unsigned ID_W = 31
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [hts_pkg::NumCorners-1:0][ID_W-1:0]      ids_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [hts_pkg::NumCorners-1:0][ID_W-1:0]      corners_o,
  output hts_pkg::diag_code_t                           code_o
);

  localparam int unsigned NumPairs = hts_pkg::NumCorners / 2;
  localparam int unsigned NumQuads = NumPairs / 2;
  localparam int unsigned NumDiag  = 6;

  // Stage registers.
  logic                                           s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [hts_pkg::NumCorners-1:0][ID_W-1:0]       s1_ids_q, s2_ids_q, s3_p_q, s4_p_q;
  logic [NumPairs-1:0][ID_W-1:0]                  s1_min_q;
  hts_pkg::corner_t [NumPairs-1:0]                s1_idx_q;
  logic [NumQuads-1:0][ID_W-1:0]                  s2_min_q;
  hts_pkg::corner_t [NumQuads-1:0]                s2_idx_q;
  logic [NumDiag-1:0][ID_W-1:0]                   s4_dmin_q;

  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  logic [NumPairs-1:0][ID_W-1:0]                  l1_min;
  hts_pkg::corner_t [NumPairs-1:0]                l1_idx;
  logic [NumQuads-1:0][ID_W-1:0]                  l2_min;
  hts_pkg::corner_t [NumQuads-1:0]                l2_idx;
  hts_pkg::corner_t                               imin;
  logic [hts_pkg::NumCorners-1:0][ID_W-1:0]       p1;
  logic [NumDiag-1:0][ID_W-1:0]                   dmin;

  function automatic logic [ID_W-1:0] min2(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  // A stage takes new data when it is empty or its content moves on.
  assign s4_rdy     = !s4_v_q || out_ready_i;
  assign s3_rdy     = !s3_v_q || s4_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  // First level of the minimum search; on a tie the lower corner wins.
  always_comb begin
    for (int j = 0; j < NumPairs; j++) begin
      if (ids_i[2*j+1] < ids_i[2*j]) begin
        l1_min[j] = ids_i[2*j+1];
        l1_idx[j] = hts_pkg::corner_t'(2*j+1);
      end else begin
        l1_min[j] = ids_i[2*j];
        l1_idx[j] = hts_pkg::corner_t'(2*j);
      end
    end
  end

  // Second level of the minimum search.
  always_comb begin
    for (int j = 0; j < NumQuads; j++) begin
      if (s1_min_q[2*j+1] < s1_min_q[2*j]) begin
        l2_min[j] = s1_min_q[2*j+1];
        l2_idx[j] = s1_idx_q[2*j+1];
      end else begin
        l2_min[j] = s1_min_q[2*j];
        l2_idx[j] = s1_idx_q[2*j];
      end
    end
  end

  // Final compare, then move the minimum corner to the front.
  always_comb begin
    imin = (s2_min_q[1] < s2_min_q[0]) ? s2_idx_q[1] : s2_idx_q[0];
    for (int i = 0; i < hts_pkg::NumCorners; i++) begin
      p1[i] = s2_ids_q[hts_pkg::PermMin[imin][i]];
    end
  end

  // Minima of the two diagonals of each of the three tested faces.
  always_comb begin
    dmin[0] = min2(s3_p_q[1], s3_p_q[6]);
    dmin[1] = min2(s3_p_q[2], s3_p_q[5]);
    dmin[2] = min2(s3_p_q[3], s3_p_q[6]);
    dmin[3] = min2(s3_p_q[2], s3_p_q[7]);
    dmin[4] = min2(s3_p_q[4], s3_p_q[6]);
    dmin[5] = min2(s3_p_q[5], s3_p_q[7]);
  end

  // Face tests; equal minima count as false.
  always_comb begin
    code_o = '0;
    code_o[hts_pkg::CodeBitFaceA] = s4_dmin_q[0] < s4_dmin_q[1];
    code_o[hts_pkg::CodeBitFaceB] = s4_dmin_q[2] < s4_dmin_q[3];
    code_o[hts_pkg::CodeBitFaceC] = s4_dmin_q[4] < s4_dmin_q[5];
  end

  assign out_valid_o = s4_v_q;
  assign corners_o   = s4_p_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (s4_rdy) begin
        s4_v_q <= s3_v_q;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_ids_q <= ids_i;
      s1_min_q <= l1_min;
      s1_idx_q <= l1_idx;
    end
    if (s2_rdy && s1_v_q) begin
      s2_ids_q <= s1_ids_q;
      s2_min_q <= l2_min;
      s2_idx_q <= l2_idx;
    end
    if (s3_rdy && s2_v_q) begin
      s3_p_q <= p1;
    end
    if (s4_rdy && s3_v_q) begin
      s4_p_q    <= s3_p_q;
      s4_dmin_q <= dmin;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hts_fifo.sv -----
`default_nettype none

module hts_fifo #(
  parameter int unsigned DATA_W = 251
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entry_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hts_back.sv -----
`default_nettype none

module hts_back #(
  parameter int unsigned ID_W = 31
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  hts_pkg::vert_t                            cfg_wdata_i,
  input  logic                                      cell_valid_i,
  output logic                                      cell_pop_o,
  input  logic [hts_pkg::NumCorners-1:0][ID_W-1:0]  cell_corners_i,
  input  hts_pkg::diag_code_t                       cell_code_i,
  input  logic                                      res_pop_i,
  output logic                                      res_valid_o,
  output hts_pkg::vert_t                            tet_number_o,
  output hts_pkg::vert_t                            vert_a_o,
  output hts_pkg::vert_t                            vert_b_o,
  output hts_pkg::vert_t                            vert_c_o,
  output hts_pkg::vert_t                            vert_d_o,
  output hts_pkg::tet_cnt_t                         tets_in_cell_o,
  output logic                                      last_o
);

  // Element numbering.
  hts_pkg::vert_t first_q, emitted_q;

  // Cell being split.
  logic                                      work_v_q;
  logic [hts_pkg::NumCorners-1:0][ID_W-1:0]  work_p_q;
  hts_pkg::ndiag_t                           work_ndiag_q;
  hts_pkg::rot_e                             work_rot_q;
  hts_pkg::tet_cnt_t                         work_cnt_q;
  hts_pkg::tet_cnt_t                         k_q;

  // Output register.
  logic              out_v_q;
  hts_pkg::vert_t    out_num_q;
  hts_pkg::vert_t    out_vert_q [hts_pkg::TetCorners];
  hts_pkg::tet_cnt_t out_cnt_q;
  logic              out_last_q;

  logic              out_rdy, emit, is_last, load;
  hts_pkg::ndiag_t   in_ndiag;
  hts_pkg::vert_t    vert [hts_pkg::TetCorners];
  hts_pkg::corner_t  src;

  assign out_rdy    = !out_v_q || res_pop_i;
  assign emit       = work_v_q && out_rdy;
  assign is_last    = k_q == work_cnt_q - hts_pkg::tet_cnt_t'(1);
  assign load       = cell_valid_i && (!work_v_q || (emit && is_last));
  assign cell_pop_o = load;

  // Number of face diagonals that run through the first corner.
  assign in_ndiag = hts_pkg::ndiag_t'(cell_code_i[0]) + hts_pkg::ndiag_t'(cell_code_i[1])
                  + hts_pkg::ndiag_t'(cell_code_i[2]);

  // Corners of the current tetrahedron, through the rotation.
  always_comb begin
    src = '0;
    for (int v = 0; v < hts_pkg::TetCorners; v++) begin
      src     = hts_pkg::rot_corner(work_rot_q, hts_pkg::TetTbl[work_ndiag_q][k_q][v]);
      vert[v] = hts_pkg::vert_t'(work_p_q[src]);
    end
  end

  // Configuration, counters and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= hts_pkg::vert_t'(1);
      emitted_q <= '0;
      work_v_q  <= 1'b0;
      k_q       <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        first_q <= cfg_wdata_i;
      end
      if (emit) begin
        emitted_q <= emitted_q + hts_pkg::vert_t'(1);
      end
      if (load) begin
        work_v_q <= 1'b1;
        k_q      <= '0;
      end else if (emit && is_last) begin
        work_v_q <= 1'b0;
        k_q      <= '0;
      end else if (emit) begin
        k_q <= k_q + hts_pkg::tet_cnt_t'(1);
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (res_pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Cell and result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      work_p_q     <= cell_corners_i;
      work_ndiag_q <= in_ndiag;
      work_rot_q   <= hts_pkg::rot_from_code(cell_code_i);
      work_cnt_q   <= (in_ndiag == '0) ? hts_pkg::TetsNoDiag : hts_pkg::TetsWithDiag;
    end
    if (emit) begin
      out_num_q  <= first_q + emitted_q;
      out_vert_q <= vert;
      out_cnt_q  <= work_cnt_q;
      out_last_q <= is_last;
    end
  end

  assign res_valid_o    = out_v_q;
  assign tet_number_o   = out_num_q;
  assign vert_a_o       = out_vert_q[0];
  assign vert_b_o       = out_vert_q[1];
  assign vert_c_o       = out_vert_q[2];
  assign vert_d_o       = out_vert_q[3];
  assign tets_in_cell_o = out_cnt_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

// ----- dv/hex_to_tet_split_tb.sv -----
`timescale 1ns / 1ps

// Corner ids of one cell, corner 1 at index 0.
typedef logic [0:7][hts_pkg::OutIdW-1:0] corner_ids_t;

// One tetrahedron as it appears on the result ports.
typedef struct packed {
  hts_pkg::vert_t    tet_num;
  hts_pkg::vert_t    vert_a;
  hts_pkg::vert_t    vert_b;
  hts_pkg::vert_t    vert_c;
  hts_pkg::vert_t    vert_d;
  hts_pkg::tet_cnt_t tets_in_cell;
  logic              last;
} tet_t;

// Corner order that moves the corner with the smallest id to the front.
localparam bit [0:7][0:7][2:0] MinFirstOrder = {
  3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
  3'd1, 3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd6,
  3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7,
  3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6,
  3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6,
  3'd5, 3'd1, 3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7,
  3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4,
  3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd5
};

// Corner order of the three rotations about the first corner.
localparam bit [0:2][0:7][2:0] TurnOrder = {
  3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
  3'd0, 3'd4, 3'd5, 3'd1, 3'd3, 3'd7, 3'd6, 3'd2,
  3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5
};

// Tetrahedra of the split, one table per number of diagonals through corner zero.
localparam bit [0:3][0:5][0:3][2:0] SplitTable = {
  3'd0, 3'd1, 3'd2, 3'd5,  3'd0, 3'd2, 3'd7, 3'd5,  3'd0, 3'd2, 3'd3, 3'd7,
  3'd0, 3'd5, 3'd7, 3'd4,  3'd2, 3'd7, 3'd5, 3'd6,  3'd0, 3'd0, 3'd0, 3'd0,
  3'd0, 3'd5, 3'd7, 3'd4,  3'd0, 3'd1, 3'd7, 3'd5,  3'd1, 3'd6, 3'd7, 3'd5,
  3'd0, 3'd7, 3'd2, 3'd3,  3'd0, 3'd7, 3'd1, 3'd2,  3'd1, 3'd7, 3'd6, 3'd2,
  3'd0, 3'd4, 3'd5, 3'd6,  3'd0, 3'd3, 3'd7, 3'd6,  3'd0, 3'd7, 3'd4, 3'd6,
  3'd0, 3'd1, 3'd2, 3'd5,  3'd0, 3'd3, 3'd6, 3'd2,  3'd0, 3'd6, 3'd5, 3'd2,
  3'd0, 3'd2, 3'd3, 3'd6,  3'd0, 3'd3, 3'd7, 3'd6,  3'd0, 3'd7, 3'd4, 3'd6,
  3'd0, 3'd5, 3'd6, 3'd4,  3'd1, 3'd5, 3'd6, 3'd0,  3'd1, 3'd6, 3'd2, 3'd0
};

// Predicts the tetrahedra of every accepted cell and checks them in order.
class tet_scoreboard;
  localparam int unsigned MaxShown = 40;

  hts_pkg::vert_t first_num;
  hts_pkg::vert_t emitted;
  tet_t           expected_tets[$];
  int unsigned    errors;

  function new();
    first_num = 31'd1;
    emitted   = '0;
    errors    = 0;
  endfunction

  function void set_first_num(hts_pkg::vert_t value);
    first_num = value;
  endfunction

  function int unsigned pending();
    return expected_tets.size();
  endfunction

  static function hts_pkg::vert_t min_of(hts_pkg::vert_t a, hts_pkg::vert_t b);
    return (b < a) ? b : a;
  endfunction

  // Face tests on ids that already have the smallest one in front; a tie is false.
  function hts_pkg::diag_code_t face_code(corner_ids_t p);
    hts_pkg::diag_code_t code;
    code = '0;
    code[hts_pkg::CodeBitFaceA] = min_of(p[1], p[6]) < min_of(p[2], p[5]);
    code[hts_pkg::CodeBitFaceB] = min_of(p[3], p[6]) < min_of(p[2], p[7]);
    code[hts_pkg::CodeBitFaceC] = min_of(p[4], p[6]) < min_of(p[5], p[7]);
    return code;
  endfunction

  function void note_cell(corner_ids_t ids);
    corner_ids_t         front;
    corner_ids_t         turned;
    hts_pkg::diag_code_t code;
    hts_pkg::rot_e       turn;
    hts_pkg::tet_cnt_t   count;
    int unsigned         low_pos;
    int unsigned         ndiag;
    tet_t                tet;
    // The lowest position wins among equal ids.
    low_pos = 0;
    for (int i = 1; i < 8; i++) begin
      if (ids[i] < ids[low_pos]) begin
        low_pos = i;
      end
    end
    for (int i = 0; i < 8; i++) begin
      front[i] = ids[MinFirstOrder[low_pos][i]];
    end
    code  = face_code(front);
    ndiag = $countones(code);
    if (code == hts_pkg::CodeRot120Lo || code == hts_pkg::CodeRot120Hi) begin
      turn = hts_pkg::ROT_120;
    end else if (code == hts_pkg::CodeRot240Lo || code == hts_pkg::CodeRot240Hi) begin
      turn = hts_pkg::ROT_240;
    end else begin
      turn = hts_pkg::ROT_NONE;
    end
    for (int i = 0; i < 8; i++) begin
      turned[i] = front[TurnOrder[turn][i]];
    end
    count = (ndiag == 0) ? hts_pkg::TetsNoDiag : hts_pkg::TetsWithDiag;
    // Element numbers wrap at the port width.
    for (int k = 0; k < count; k++) begin
      tet.tet_num      = first_num + emitted;
      tet.vert_a       = turned[SplitTable[ndiag][k][0]];
      tet.vert_b       = turned[SplitTable[ndiag][k][1]];
      tet.vert_c       = turned[SplitTable[ndiag][k][2]];
      tet.vert_d       = turned[SplitTable[ndiag][k][3]];
      tet.tets_in_cell = count;
      tet.last         = (k == count - 1);
      expected_tets.push_back(tet);
      emitted = emitted + 31'd1;
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= MaxShown) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  task check_field(string name, hts_pkg::vert_t got, hts_pkg::vert_t want);
    if (got !== want) begin
      report($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task check_tet(tet_t got);
    tet_t want;
    if (expected_tets.size() == 0) begin
      report("tetrahedron popped while none was expected");
    end else begin
      want = expected_tets.pop_front();
      check_field("tet_number", got.tet_num, want.tet_num);
      check_field("vert_a", got.vert_a, want.vert_a);
      check_field("vert_b", got.vert_b, want.vert_b);
      check_field("vert_c", got.vert_c, want.vert_c);
      check_field("vert_d", got.vert_d, want.vert_d);
      check_field("tets_in_cell", hts_pkg::vert_t'(got.tets_in_cell),
                  hts_pkg::vert_t'(want.tets_in_cell));
      check_field("last", hts_pkg::vert_t'(got.last), hts_pkg::vert_t'(want.last));
    end
  endtask
endclass

module hex_to_tet_split_tb;

  localparam int unsigned LongHoldCycles = 150;
  localparam int unsigned StuckLimit     = 2000;
  localparam int unsigned DrainTail      = 20;

  typedef enum {SinkStream, SinkRandom, SinkPattern} sink_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  hts_pkg::vert_t    cfg_wdata_i = '0;
  logic              push = 1'b0;
  logic              full;
  hts_pkg::vert_t    vertex_id_1_i = '0;
  hts_pkg::vert_t    vertex_id_2_i = '0;
  hts_pkg::vert_t    vertex_id_3_i = '0;
  hts_pkg::vert_t    vertex_id_4_i = '0;
  hts_pkg::vert_t    vertex_id_5_i = '0;
  hts_pkg::vert_t    vertex_id_6_i = '0;
  hts_pkg::vert_t    vertex_id_7_i = '0;
  hts_pkg::vert_t    vertex_id_8_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  hts_pkg::vert_t    tet_number_o;
  hts_pkg::vert_t    vert_a_o;
  hts_pkg::vert_t    vert_b_o;
  hts_pkg::vert_t    vert_c_o;
  hts_pkg::vert_t    vert_d_o;
  hts_pkg::tet_cnt_t tets_in_cell_o;
  logic              last_o;

  bit                long_hold_req = 1'b0;
  int unsigned       stuck_cycles = 0;
  tet_scoreboard     sb = new();

  always #6 clk_i = ~clk_i;

  hex_to_tet_split uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .vertex_id_1_i  (vertex_id_1_i),
    .vertex_id_2_i  (vertex_id_2_i),
    .vertex_id_3_i  (vertex_id_3_i),
    .vertex_id_4_i  (vertex_id_4_i),
    .vertex_id_5_i  (vertex_id_5_i),
    .vertex_id_6_i  (vertex_id_6_i),
    .vertex_id_7_i  (vertex_id_7_i),
    .vertex_id_8_i  (vertex_id_8_i),
    .empty          (empty),
    .pop            (pop),
    .tet_number_o   (tet_number_o),
    .vert_a_o       (vert_a_o),
    .vert_b_o       (vert_b_o),
    .vert_c_o       (vert_c_o),
    .vert_d_o       (vert_d_o),
    .tets_in_cell_o (tets_in_cell_o),
    .last_o         (last_o)
  );

  // Every register write, accepted cell and popped tetrahedron goes to the scoreboard.
  always @(posedge clk_i) begin : monitor
    tet_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        sb.set_first_num(cfg_wdata_i);
      end
      if (push && !full) begin
        sb.note_cell({vertex_id_1_i, vertex_id_2_i, vertex_id_3_i, vertex_id_4_i,
                      vertex_id_5_i, vertex_id_6_i, vertex_id_7_i, vertex_id_8_i});
      end
      if (pop && !empty) begin
        got.tet_num      = tet_number_o;
        got.vert_a       = vert_a_o;
        got.vert_b       = vert_b_o;
        got.vert_c       = vert_c_o;
        got.vert_d       = vert_d_o;
        got.tets_in_cell = tets_in_cell_o;
        got.last         = last_o;
        sb.check_tet(got);
      end
    end
  end

  // The run ends if neither side completes a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The result side switches between streaming, random stalls and a fixed stall pattern,
  // and holds off for a long stretch when asked.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned period;
    int unsigned stall_len;
    int unsigned phase;
    mode      = SinkStream;
    mode_left = 0;
    period    = 2;
    stall_len = 1;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(2, 0));
        mode_left = $urandom_range(300, 40);
        period    = $urandom_range(9, 2);
        stall_len = $urandom_range(period - 1, 1);
        phase     = 0;
      end
      mode_left--;
      phase = (phase + 1) % period;
      case (mode)
        SinkStream: begin
          pop <= 1'b1;
        end
        SinkRandom: begin
          pop <= ($urandom_range(1, 0) == 1);
        end
        default: begin
          pop <= (phase >= stall_len);
        end
      endcase
    end
  end

  // Offers one cell and returns at the edge where it is taken.
  task automatic send_cell(input corner_ids_t ids);
    if (!push) begin
      push <= 1'b1;
    end
    {vertex_id_1_i, vertex_id_2_i, vertex_id_3_i, vertex_id_4_i,
     vertex_id_5_i, vertex_id_6_i, vertex_id_7_i, vertex_id_8_i} <= ids;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
  endtask

  task automatic pause_sender(input int unsigned cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops offering and waits until every predicted tetrahedron has been popped.
  task automatic drain_results();
    push <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.pending() != 0);
  endtask

  task automatic set_first_number(input hts_pkg::vert_t value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly full-range ids; some cells draw from a tiny range to force equal ids.
  function automatic corner_ids_t random_cell();
    corner_ids_t ids;
    int unsigned kind;
    kind = $urandom_range(9, 0);
    for (int i = 0; i < 8; i++) begin
      if (kind < 6 || (kind == 9 && $urandom_range(1, 0) == 1)) begin
        ids[i] = hts_pkg::vert_t'($urandom());
      end else begin
        ids[i] = hts_pkg::vert_t'($urandom_range(7, 0));
      end
    end
    return ids;
  endfunction

  task automatic send_random_cells(input int unsigned count);
    int unsigned burst;
    while (count > 0) begin
      burst = $urandom_range(12, 1);
      if (burst > count) begin
        burst = count;
      end
      count -= burst;
      repeat (burst) send_cell(random_cell());
      if ($urandom_range(3, 0) != 0) begin
        pause_sender($urandom_range(8, 1));
      end
    end
  endtask

  // Searches small ids with corner one lowest until the face tests give the code.
  task automatic send_cell_with_code(input hts_pkg::diag_code_t code);
    corner_ids_t ids;
    do begin
      for (int i = 1; i < 8; i++) begin
        ids[i] = hts_pkg::vert_t'($urandom_range(40, 1));
      end
      ids[0] = '0;
    end while (sb.face_code(ids) != code);
    send_cell(ids);
  endtask

  initial begin : stimulus
    corner_ids_t ids;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cells with the reset element number: extremes, alternating bits,
    // the minimum at each corner, a tie for the minimum, and every diagonal code.
    ids = '0;
    send_cell(ids);
    ids = '1;
    send_cell(ids);
    for (int i = 0; i < 8; i++) begin
      ids[i] = (i % 2 == 0) ? 31'h5555_5555 : 31'h2AAA_AAAA;
    end
    send_cell(ids);
    send_cell(~ids);
    for (int p = 0; p < 8; p++) begin
      for (int i = 0; i < 8; i++) begin
        ids[i] = hts_pkg::vert_t'($urandom_range(1000, 100));
      end
      ids[p] = 31'd7;
      send_cell(ids);
    end
    for (int i = 0; i < 8; i++) begin
      ids[i] = 31'd50;
    end
    ids[2] = 31'd3;
    ids[6] = 31'd3;
    send_cell(ids);
    pause_sender(3);
    for (int c = 0; c < 8; c++) begin
      send_cell_with_code(c[2:0]);
    end
    drain_results();

    // Element numbers that wrap past the top of the range shortly.
    set_first_number(31'h7FFF_FFF0 - sb.emitted);
    send_random_cells(60);

    // The result side holds off while cells keep coming, so the input stalls.
    long_hold_req = 1'b1;
    repeat (30) send_cell(random_cell());
    drain_results();

    set_first_number('0);
    send_random_cells(100);
    drain_results();

    set_first_number(31'h7FFF_FFFF);
    send_random_cells(100);
    drain_results();

    set_first_number(hts_pkg::vert_t'($urandom()));
    send_random_cells(100);
    drain_results();

    repeat (DrainTail) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
